@@ rtl/sha256_message_digest_core_assert.svh @@
// Assertion macros for the SHA-256 digest core.
`ifndef SHA256_MESSAGE_DIGEST_CORE_ASSERT_SVH
`define SHA256_MESSAGE_DIGEST_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/sha256_pkg.sv @@
// Types, constants and round functions shared by the SHA-256 digest core.
`default_nettype none
package sha256_pkg;
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    typedef struct packed {
        logic start;
        logic init;
    } t_rnd_ctrl;

    localparam logic [7:0] PadMark = 8'h80;
    localparam logic [5:0] LenPos  = 6'd56;

    localparam logic [31:0] InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction
endpackage
`default_nettype wire

@@ rtl/sha256_round.sv @@
// One SHA-256 round unit with rolling message schedule, reused for all 64 rounds.
`default_nettype none
module sha256_round (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  sha256_pkg::t_rnd_ctrl     i_ctrl,
    input  wire logic [511:0]         i_block,
    input  wire logic [255:0]         i_hash,
    output logic [255:0]              o_hash,
    output logic                      o_done
);
    import sha256_pkg::*;

    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [31:0] r_h [8];
    logic [6:0]  r_round;
    logic        r_busy;
    logic        r_done;

    logic [5:0]  rnd;
    logic [31:0] w_cur, s0, s1, t1, t2, ch, maj, ep0, ep1;

    assign rnd = r_round[5:0];

    always_comb begin
        s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_cur = (r_round < 7'd16) ? r_w[0] : (s1 + r_w[9] + s0 + r_w[0]);
        ep1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        ep0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1 = r_v[7] + ep1 + ch + RoundK[rnd] + w_cur;
        t2 = ep0 + maj;
    end

    // The schedule window shifts one word per round; slot 0 is word r (r-16 if r>15).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_round <= '0;
            for (int k = 0; k < 8; k++) r_h[k] <= InitHash[k];
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.init) begin
                for (int k = 0; k < 8; k++) r_h[k] <= InitHash[k];
            end
            if (i_ctrl.start) begin
                for (int k = 0; k < 16; k++) r_w[k] <= i_block[511 - 32*k -: 32];
                for (int k = 0; k < 8; k++) r_v[k] <= i_hash[255 - 32*k -: 32];
                r_busy  <= 1'b1;
                r_round <= '0;
            end else if (r_busy) begin
                for (int k = 0; k < 15; k++) r_w[k] <= r_w[k+1];
                r_w[15] <= w_cur;
                r_v[7] <= r_v[6];
                r_v[6] <= r_v[5];
                r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2];
                r_v[2] <= r_v[1];
                r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
                if (r_round == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_round <= '0;
                end else begin
                    r_round <= r_round + 7'd1;
                end
            end else if (r_done) begin
                for (int k = 0; k < 8; k++) r_h[k] <= i_hash[255 - 32*k -: 32] + r_v[k];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 8; k++) o_hash[255 - 32*k -: 32] = r_h[k];
    end
    assign o_done = r_done;
endmodule
`default_nettype wire

@@ rtl/sha256_message_digest_core.sv @@
// Top level of the byte-serial SHA-256 digest core: sequencer, block buffer, output.
//
// Channel   Dir  Handshake              Payload
// in        in   i_valid / o_ready      sha256_pkg::t_in_item
// out       out  o_valid / i_ready      sha256_pkg::t_out_item
//
// A byte that does not fill the block is taken in S_IDLE and then written
// in S_BYTE. A byte that completes a 64-byte block holds o_ready low while
// the shared round unit runs its 64 rounds and folds the result into the
// hash. An end of message pushes padding bytes through the same path, one per
// cycle outside compression, compresses one or two blocks, then shows the
// eight digest words one per accepted output item. Reset is synchronous and
// returns the hash to the standard initial values. Output stalls only hold
// the current word; no input is taken until the eighth word has left.
`default_nettype none
module sha256_message_digest_core (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  sha256_pkg::t_in_item       i_item,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output sha256_pkg::t_out_item      o_item
);
    import sha256_pkg::*;
`include "sha256_message_digest_core_assert.svh"

    typedef enum logic [2:0] {
        S_IDLE, S_BYTE, S_COMP, S_WAIT, S_PAD, S_OUT
    } t_state;

    t_state       r_state;
    logic [511:0] r_block;
    logic [63:0]  r_bits;
    logic [63:0]  r_len;
    logic [5:0]   r_pos;
    logic         r_end;
    logic         r_pad_started;
    logic         r_len_here;
    logic [7:0]   r_byte;
    logic [2:0]   r_widx;
    logic         r_valid;
    t_rnd_ctrl    rnd_ctrl;
    logic [255:0] hash;
    logic         comp_done;
    logic [7:0]   pad_byte;
    logic [2:0]   len_sel;

    sha256_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (rnd_ctrl),
        .i_block (r_block),
        .i_hash  (hash),
        .o_hash  (hash),
        .o_done  (comp_done)
    );

    // Padding: 0x80 first, zeros to byte 56, then the length big-endian.
    // The length goes only into the block that has room for it after the
    // 0x80 byte; when the 0x80 lands at byte 56 or later, that block is
    // filled with zeros and the length goes into the following block.
    always_comb begin
        len_sel = 3'd7 - r_pos[2:0];
        if (!r_pad_started) begin
            pad_byte = PadMark;
        end else if (r_len_here && r_pos >= LenPos) begin
            pad_byte = r_len[8*len_sel +: 8];
        end else begin
            pad_byte = '0;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;
    assign o_item.digest_word = hash[255 - 32*r_widx -: 32];
    assign o_item.word_index  = r_widx;
    assign o_item.last_word   = (r_widx == 3'd7);

    always_comb begin
        rnd_ctrl.start = (r_state == S_COMP);
        rnd_ctrl.init  = (r_state == S_OUT) && r_valid && i_ready && (r_widx == 3'd7);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_bits        <= '0;
            r_pos         <= '0;
            r_end         <= 1'b0;
            r_pad_started <= 1'b0;
            r_len_here    <= 1'b0;
            r_widx        <= '0;
            r_valid       <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_byte <= i_item.data_byte;
                        r_end  <= i_item.end_of_message;
                        r_pad_started <= 1'b0;
                        if (i_item.byte_valid) begin
                            r_bits  <= r_bits + 64'd8;
                            r_len   <= r_bits + 64'd8;
                            r_state <= S_BYTE;
                        end else if (i_item.end_of_message) begin
                            r_len   <= r_bits;
                            r_state <= S_PAD;
                        end
                    end
                end
                S_BYTE, S_PAD: begin
                    r_block[511 - 8*r_pos -: 8] <= (r_state == S_BYTE) ? r_byte : pad_byte;
                    if (r_state == S_PAD) r_pad_started <= 1'b1;
                    // The 0x80 byte decides whether the length still fits here.
                    if (r_state == S_PAD && !r_pad_started) r_len_here <= (r_pos < LenPos);
                    r_pos <= r_pos + 6'd1;
                    if (r_pos == 6'd63) begin
                        r_state <= S_COMP;
                    end else if (r_state == S_PAD || r_end) begin
                        r_state <= S_PAD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_COMP: r_state <= S_WAIT;
                S_WAIT: begin
                    if (comp_done) begin
                        // The hash update lands in the cycle after done.
                        if (r_end && r_pad_started && r_len_here && r_pos == 6'd0) begin
                            r_state <= S_OUT;
                            r_widx  <= '0;
                        end else if (r_end) begin
                            r_state    <= S_PAD;
                            r_len_here <= 1'b1;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_valid) begin
                        r_valid <= 1'b1;
                    end else if (i_ready) begin
                        if (r_widx == 3'd7) begin
                            r_valid <= 1'b0;
                            r_bits  <= '0;
                            r_end   <= 1'b0;
                            r_state <= S_IDLE;
                        end
                        r_widx <= r_widx + 3'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output items appear only while the digest is being delivered.
    `SHA_ASSERT_IMP(a_valid_in_out, i_clk, i_rst_n, o_valid, r_state == S_OUT)
    // The core never takes an input while results are pending.
    `SHA_ASSERT_IMP(a_no_ready_busy, i_clk, i_rst_n, o_valid, !o_ready)
    // After the last word leaves, the core returns to idle.
    `SHA_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n,
        o_valid && i_ready && o_item.last_word, o_ready && !o_valid)
endmodule
`default_nettype wire

@@ dv/sha256_message_digest_core_tb.sv @@
// Self-checking testbench for the byte-serial SHA-256 digest core.
`default_nettype none
module sha256_message_digest_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sha256_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    // Clock with a 2 ns period.
    always #1 clk = ~clk;

    sha256_message_digest_core uut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_valid(in_valid),
        .o_ready(in_ready),
        .i_item (in_item),
        .o_valid(out_valid),
        .i_ready(out_ready),
        .o_item (out_item)
    );

    localparam logic [31:0] StartHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    localparam logic [31:0] RoundConst [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Shadow copy of the hashing state, advanced once per accepted item.
    logic [31:0] mdl_hash [8];
    logic [31:0] mdl_block [16];
    logic [63:0] mdl_bits;
    logic [5:0]  mdl_pos;

    t_in_item  pending_items [$];
    t_out_item digest_words_due [$];
    int        mismatches;
    bit        sender_pause;
    int        receiver_hold;

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // One 64-round compression of the buffered block into the shadow hash.
    function automatic void compress_shadow();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] wr, t1, t2, x2, x15;
        for (int i = 0; i < 16; i++) w[i] = mdl_block[i];
        for (int i = 0; i < 8; i++) v[i] = mdl_hash[i];
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                wr = w[r];
            end else begin
                x2  = w[(r - 2) & 15];
                x15 = w[(r - 15) & 15];
                wr = (ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10)) + w[(r - 7) & 15]
                     + (ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3)) + w[r & 15];
                w[r & 15] = wr;
            end
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[r] + wr;
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) mdl_hash[i] += v[i];
    endfunction

    function automatic void absorb_byte(logic [7:0] b);
        mdl_block[mdl_pos[5:2]][(3 - mdl_pos[1:0]) * 8 +: 8] = b;
        if (mdl_pos == 6'd63) compress_shadow();
        mdl_pos = mdl_pos + 6'd1;
    endfunction

    function automatic void shadow_restart();
        for (int i = 0; i < 8; i++) mdl_hash[i] = StartHash[i];
        mdl_bits = '0;
        mdl_pos  = '0;
    endfunction

    // Feeds one accepted item; on end of message pads and queues the digest.
    function automatic void predict_digest(t_in_item it);
        logic [63:0] len;
        t_out_item   w;
        if (it.byte_valid) begin
            absorb_byte(it.data_byte);
            mdl_bits += 64'd8;
        end
        if (it.end_of_message) begin
            len = mdl_bits;
            absorb_byte(PadMark);
            while (mdl_pos != LenPos) absorb_byte(8'h00);
            for (int i = 7; i >= 0; i--) absorb_byte(len[i * 8 +: 8]);
            for (int i = 0; i < 8; i++) begin
                w.digest_word = mdl_hash[i];
                w.word_index  = 3'(i);
                w.last_word   = (i == 7);
                digest_words_due = {digest_words_due, w};
            end
            shadow_restart();
        end
    endfunction

    function automatic t_in_item make_item(bit v, bit e, logic [7:0] d);
        t_in_item it;
        it.data_byte = d;
        it.byte_valid = v;
        it.end_of_message = e;
        return it;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic void enqueue_item(t_in_item it);
        pending_items = {pending_items, it};
    endfunction

    function automatic void queue_message(int nbytes);
        for (int i = 0; i < nbytes; i++) begin
            enqueue_item(make_item(1'b1, 1'b0, 8'($urandom)));
        end
        // Stray items with neither byte nor end are ignored by the core.
        if ($urandom_range(9) == 0) enqueue_item(make_item(1'b0, 1'b0, 8'($urandom)));
        if ($urandom_range(1)) begin
            enqueue_item(make_item(1'b1, 1'b1, 8'($urandom)));
        end else begin
            enqueue_item(make_item(1'b0, 1'b1, 8'($urandom)));
        end
    endfunction

    // Input acceptance is taken at the rising edge, where the handshake counts.
    bit in_taken = 1'b0;
    int accepted_items = 0;
    always @(posedge clk) begin
        in_taken = rst_n && in_valid && in_ready;
        if (in_taken) begin
            predict_digest(in_item);
            accepted_items++;
        end
    end

    // Driver: inputs change on the falling edge only.
    int drv_gap = 0;
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (drv_gap > 0) begin
                drv_gap <= drv_gap - 1;
                in_valid <= 1'b0;
            end else if (sender_pause || pending_items.size() == 0) begin
                in_valid <= 1'b0;
            end else begin
                in_item  <= pending_items.pop_front();
                in_valid <= 1'b1;
                drv_gap  <= gap_len();
            end
        end
    end

    // Receiver ready pattern, with an optional long hold-off counted here.
    int rcv_gap = 0;
    always @(negedge clk) begin
        if (receiver_hold > 0) begin
            receiver_hold <= receiver_hold - 1;
            out_ready <= 1'b0;
        end else if (rcv_gap > 0) begin
            rcv_gap <= rcv_gap - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            rcv_gap <= gap_len();
        end
    end

    // Monitor: compare each accepted digest word with the oldest expectation.
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (digest_words_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected digest word %h", out_item);
            end else begin
                want = digest_words_due.pop_front();
                if (out_item.digest_word !== want.digest_word
                    || out_item.word_index !== want.word_index
                    || out_item.last_word !== want.last_word) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch: expected word %h index %0d last %b, got %h %0d %b",
                                 want.digest_word, want.word_index, want.last_word,
                                 out_item.digest_word, out_item.word_index,
                                 out_item.last_word);
                    end
                end
            end
        end
    end

    initial begin
        int lens [6];
        mismatches = 0;
        sender_pause = 1'b0;
        receiver_hold = 0;
        shadow_restart();
        for (int i = 0; i < 16; i++) mdl_block[i] = '0;

        // Directed: empty message, byte with end, extreme bytes, ignored item,
        // ignored byte value, and lengths around the padding boundaries.
        enqueue_item(make_item(1'b0, 1'b1, 8'hff));
        enqueue_item(make_item(1'b0, 1'b0, 8'hff));
        enqueue_item(make_item(1'b1, 1'b1, 8'h00));
        enqueue_item(make_item(1'b1, 1'b0, 8'hff));
        enqueue_item(make_item(1'b1, 1'b0, 8'h00));
        enqueue_item(make_item(1'b1, 1'b1, 8'hff));
        enqueue_item(make_item(1'b0, 1'b0, 8'h5a));
        enqueue_item(make_item(1'b0, 1'b1, 8'ha5));

        repeat (7) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // Sender pause: wait for every digest before continuing.
        wait (pending_items.size() == 0 && !in_valid && digest_words_due.size() == 0);
        sender_pause = 1'b1;
        repeat (100) @(posedge clk);
        lens = '{55, 56, 63, 64, 1, 3};
        foreach (lens[k]) queue_message(lens[k] - 1);
        sender_pause = 1'b0;

        // Long receiver hold-off while the sender keeps offering items.
        wait (digest_words_due.size() > 0);
        receiver_hold = 400;

        // Random part: messages mostly short, a few spanning blocks.
        while (accepted_items + pending_items.size() + int'(in_valid) < 440) begin
            if ($urandom_range(9) == 0) queue_message($urandom_range(50, 90));
            else queue_message($urandom_range(0, 12));
        end

        wait (pending_items.size() == 0 && !in_valid);
        wait (digest_words_due.size() == 0);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && digest_words_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+rtl
rtl/sha256_pkg.sv
rtl/sha256_round.sv
rtl/sha256_message_digest_core.sv
dv/sha256_message_digest_core_tb.sv
